// File: rtl/tcw_pkg.sv
// Shared types, constants and defaults for the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS     = 80;
    localparam int DEF_ROWS        = 25;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int POS_OUT_W = 11;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ERROR   = 8'h45;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BLANK   = 8'h00;

    localparam logic [7:0] RESET_DEFAULT_ATTR = 8'd15;
    localparam logic [7:0] RESET_ERROR_ATTR   = 8'd244;

    localparam logic [1:0] REG_DEFAULT_ATTR  = 2'd0;
    localparam logic [1:0] REG_ERROR_ATTR    = 2'd1;
    localparam logic [1:0] REG_CURSOR_FOLLOW = 2'd2;

    typedef enum logic [1:0] {
        OP_PRINT,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } back_state_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic       use_position;
        logic [6:0] column;
        logic [4:0] line;
        logic       bad;
        logic       newline;
    } cmd_t;

    typedef struct packed {
        logic [7:0] default_attribute;
        logic [7:0] error_attribute;
        logic       cursor_follow;
    } cfg_t;

    // Packed so that next_position sits in the low bits.
    typedef struct packed {
        logic [7:0]           cell_attribute;
        logic [7:0]           cell_char;
        logic                 scrolled;
        logic                 error;
        logic [POS_OUT_W-1:0] cursor_now;
        logic [POS_OUT_W-1:0] next_position;
    } res_t;

endpackage

// File: rtl/text_console_writer.sv
// Top level: config registers, front end, command queue and back end.
// Each word is queued before the back end takes it; a cell read also passes the read
// register. Throughput: one print or backspace per cycle unless stalled by the receiver,
// a scroll or clear; a read holds the back end in its read state, a scroll while it moves
// rows up, a clear while it fills every cell. Reset: cursor homes, registers take their
// defaults, and a clearing pass zeroes the frame store while s_tready stays low.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int ROWS        = DEF_ROWS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code, attribute, use_position, column, line
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // next_position, cursor_now, error, scrolled,
                                   // cell_char, cell_attribute
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg, cfg_next;
    logic cfg_wr;
    logic q_full;
    logic q_push;
    cmd_t q_push_data;
    logic q_pop;
    logic q_valid;
    cmd_t q_data;
    logic init_busy;
    res_t res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign m_tdata = res;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (paddr[3:2])
            REG_DEFAULT_ATTR:
            begin
                prdata = {24'd0, cfg_reg.default_attribute};
                if (cfg_wr)
                begin
                    cfg_next.default_attribute = pwdata[7:0];
                end
            end
            REG_ERROR_ATTR:
            begin
                prdata = {24'd0, cfg_reg.error_attribute};
                if (cfg_wr)
                begin
                    cfg_next.error_attribute = pwdata[7:0];
                end
            end
            REG_CURSOR_FOLLOW:
            begin
                prdata = {31'd0, cfg_reg.cursor_follow};
                if (cfg_wr)
                begin
                    cfg_next.cursor_follow = pwdata[0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_attribute <= RESET_DEFAULT_ATTR;
            cfg_reg.error_attribute   <= RESET_ERROR_ATTR;
            cfg_reg.cursor_follow     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

endmodule

// File: rtl/tcw_front.sv
// Front end: takes input words, decodes the command and checks the position.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code, attribute, use_position, column, line
    input  logic [1:0]  s_tuser,   // command
    input  logic        q_full,
    input  logic        init_busy,
    output logic        q_push,
    output cmd_t        q_data
);

    logic [6:0] col;
    logic [4:0] row;
    logic       use_pos;

    assign col     = s_tdata[23:17];
    assign row     = s_tdata[28:24];
    assign use_pos = s_tdata[16];

    assign s_tready = !q_full && !init_busy;
    assign q_push   = s_tvalid && s_tready;

    always_comb
    begin
        q_data.op           = op_t'(s_tuser);
        q_data.char_code    = s_tdata[7:0];
        q_data.attribute    = s_tdata[15:8];
        q_data.use_position = use_pos;
        q_data.column       = col;
        q_data.line         = row;
        q_data.bad          = use_pos && ((32'(col) >= COLUMNS) || (32'(row) >= ROWS));
        q_data.newline      = (s_tdata[7:0] == CH_NEWLINE);
    end

endmodule

// File: rtl/tcw_queue.sv
// Short command queue between the front end and the back end.
module tcw_queue
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full      = (count_reg == NW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/tcw_back.sv
// Back end: cursor, frame store, scroll and fill sequencer, result register.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_data,
    output logic q_pop,
    input  cfg_t cfg,
    output logic init_busy,
    output logic m_tvalid,
    input  logic m_tready,
    output res_t res
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int MOVE   = CELLS - COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);

    function automatic logic [ADDR_W-1:0] cell_index(input logic [RW-1:0] r,
                                                     input logic [CW-1:0] c);
        return ADDR_W'(32'(r) * COLUMNS + 32'(c));
    endfunction

    logic [15:0]       frame_mem [CELLS];
    logic [15:0]       rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [15:0]       fill_reg, fill_next;
    logic              reply_reg, reply_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    logic [RW-1:0]     pos_row;
    logic [CW-1:0]     pos_col;
    logic [RW-1:0]     new_row;
    logic [CW-1:0]     new_col;
    logic [7:0]        attr_sel;
    logic              adv_row;
    logic              scroll;
    logic [ADDR_W-1:0] cur_lin;

    assign m_tvalid  = out_valid_reg;
    assign res       = res_reg;
    assign init_busy = (state_reg == ST_FILL) && !reply_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        reply_next     = reply_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = '0;
        cur_lin        = cell_index(cur_row_reg, cur_col_reg);
        pos_row        = q_data.use_position ? RW'(q_data.line) : cur_row_reg;
        pos_col        = q_data.use_position ? CW'(q_data.column) : cur_col_reg;
        attr_sel       = (q_data.attribute == '0) ? cfg.default_attribute : q_data.attribute;
        adv_row        = q_data.newline || (32'(pos_col) == COLUMNS - 1);
        scroll         = adv_row && (32'(pos_row) == ROWS - 1);
        new_row        = pos_row;
        new_col        = pos_col;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    res_next.next_position  = POS_OUT_W'(cur_lin);
                    res_next.cursor_now     = POS_OUT_W'(cur_lin);
                    res_next.error          = 1'b0;
                    res_next.scrolled       = 1'b0;
                    res_next.cell_char      = '0;
                    res_next.cell_attribute = '0;
                    out_valid_next          = 1'b1;
                    case (q_data.op)
                        OP_PRINT:
                        begin
                            if (q_data.bad)
                            begin
                                mem_we         = 1'b1;
                                mem_wa         = ADDR_W'(CELLS - 1);
                                mem_wd         = {cfg.error_attribute, CH_ERROR};
                                res_next.error = 1'b1;
                            end
                            else
                            begin
                                if (!q_data.newline)
                                begin
                                    mem_we = 1'b1;
                                    mem_wa = cell_index(pos_row, pos_col);
                                    mem_wd = {attr_sel, q_data.char_code};
                                end
                                if (adv_row)
                                begin
                                    new_col = '0;
                                    if (!scroll)
                                    begin
                                        new_row = pos_row + RW'(1);
                                    end
                                end
                                else
                                begin
                                    new_col = pos_col + CW'(1);
                                end
                                res_next.next_position = POS_OUT_W'(cell_index(new_row, new_col));
                                res_next.scrolled      = scroll;
                                if (cfg.cursor_follow)
                                begin
                                    cur_row_next        = new_row;
                                    cur_col_next        = new_col;
                                    res_next.cursor_now = POS_OUT_W'(cell_index(new_row, new_col));
                                end
                                if (scroll)
                                begin
                                    out_valid_next = 1'b0;
                                    cnt_next       = '0;
                                    state_next     = ST_SCROLL;
                                end
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if ((cur_row_reg != '0) || (cur_col_reg != '0))
                            begin
                                if (cur_col_reg == '0)
                                begin
                                    new_col = CW'(COLUMNS - 1);
                                    new_row = cur_row_reg - RW'(1);
                                end
                                else
                                begin
                                    new_col = cur_col_reg - CW'(1);
                                    new_row = cur_row_reg;
                                end
                                cur_row_next           = new_row;
                                cur_col_next           = new_col;
                                mem_we                 = 1'b1;
                                mem_wa                 = cell_index(new_row, new_col);
                                mem_wd                 = {cfg.default_attribute, CH_BLANK};
                                res_next.next_position = POS_OUT_W'(mem_wa);
                                res_next.cursor_now    = POS_OUT_W'(mem_wa);
                            end
                        end
                        OP_CLEAR:
                        begin
                            cur_row_next           = '0;
                            cur_col_next           = '0;
                            res_next.next_position = '0;
                            res_next.cursor_now    = '0;
                            out_valid_next         = 1'b0;
                            fill_next              = {cfg.default_attribute, CH_SPACE};
                            reply_next             = 1'b1;
                            cnt_next               = '0;
                            state_next             = ST_FILL;
                        end
                        default:
                        begin
                            if (q_data.bad)
                            begin
                                res_next.error = 1'b1;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                mem_ra         = cell_index(pos_row, pos_col);
                                state_next     = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.cell_char      = rd_data_reg[7:0];
                res_next.cell_attribute = rd_data_reg[15:8];
                out_valid_next          = 1'b1;
                state_next              = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the word read last cycle
                if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = cnt_reg - ADDR_W'(1);
                    mem_wd = rd_data_reg;
                end
                if (cnt_reg == ADDR_W'(MOVE))
                begin
                    fill_next  = '0;
                    reply_next = 1'b1;
                    state_next = ST_FILL;
                end
                else
                begin
                    mem_ra   = ADDR_W'(32'(cnt_reg) + COLUMNS);
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg;
                mem_wd = fill_reg;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    out_valid_next = reply_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            reply_reg     <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            reply_reg     <= reply_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= frame_mem[mem_ra];
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_row_reg) < ROWS)
        else $error("cursor row out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command taken while sequencer busy");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !out_valid_reg)
        else $error("result shown during reset clearing pass");

    a_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> out_valid_reg)
        else $error("cell read gave no result");

endmodule

// File: verif/tcw_checker.sv
// Scoreboard for the text console writer: tracks the frame store and cursor, checks every result.
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending,
    output int          results_checked,
    output int          scroll_total,
    output int          range_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = COLUMNS * ROWS;

    logic [15:0] screen [CELLS];
    int unsigned cursor_pos;
    logic [7:0]  dflt_attr;
    logic [7:0]  err_attr;
    logic        follow_cursor;
    res_t        expected_q [$];
    res_t        want;
    res_t        got;
    res_t        predicted;

    task automatic report(input string msg);
        $display("[%0t] console mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] seen,
                               input logic [15:0] ref_val);
        if (seen !== ref_val)
            report($sformatf("%s got %0d, expected %0d", name, seen, ref_val));
    endtask

    function automatic res_t apply_word(op_t op, logic [7:0] ch, logic [7:0] attr,
                                        logic use_pos, logic [6:0] col, logic [4:0] row);
        res_t        r;
        int unsigned pos;
        int unsigned nxt;
        logic        bad;
        r   = '0;
        pos = cursor_pos;
        nxt = cursor_pos;
        bad = 1'b0;
        if (use_pos) begin
            if (col >= COLUMNS || row >= ROWS)
                bad = 1'b1;
            else
                pos = row * COLUMNS + col;
        end
        case (op)
            OP_PRINT:
            begin
                if (bad) begin
                    screen[CELLS-1] = {err_attr, CH_ERROR};
                    r.error = 1'b1;
                end else begin
                    if (attr == 8'h00)
                        attr = dflt_attr;
                    if (ch == CH_NEWLINE)
                        nxt = (pos / COLUMNS + 1) * COLUMNS;
                    else begin
                        screen[pos] = {attr, ch};
                        nxt = pos + 1;
                    end
                    if (nxt >= CELLS) begin
                        for (int i = 0; i < CELLS - COLUMNS; i++)
                            screen[i] = screen[i + COLUMNS];
                        for (int i = CELLS - COLUMNS; i < CELLS; i++)
                            screen[i] = '0;
                        r.scrolled = 1'b1;
                        nxt -= COLUMNS;
                    end
                    if (follow_cursor)
                        cursor_pos = nxt;
                end
            end
            OP_BACKSPACE:
            begin
                if (cursor_pos != 0) begin
                    cursor_pos--;
                    screen[cursor_pos] = {dflt_attr, CH_BLANK};
                end
                nxt = cursor_pos;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = {dflt_attr, CH_SPACE};
                cursor_pos = 0;
                nxt = 0;
            end
            default:
            begin
                if (bad)
                    r.error = 1'b1;
                else begin
                    r.cell_char      = screen[pos][7:0];
                    r.cell_attribute = screen[pos][15:8];
                end
            end
        endcase
        r.next_position = nxt[POS_OUT_W-1:0];
        r.cursor_now    = cursor_pos[POS_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = '0;
            cursor_pos      = 0;
            dflt_attr       = RESET_DEFAULT_ATTR;
            err_attr        = RESET_ERROR_ATTR;
            follow_cursor   = 1'b1;
            expected_q.delete();
            mismatches      = 0;
            results_checked = 0;
            scroll_total    = 0;
            range_total     = 0;
            pending        <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0)
                    report("result word with nothing expected");
                else begin
                    want = expected_q.pop_front();
                    got  = res_t'(m_tdata);
                    check_field("next_position", 16'(got.next_position), 16'(want.next_position));
                    check_field("cursor_now", 16'(got.cursor_now), 16'(want.cursor_now));
                    check_field("error", 16'(got.error), 16'(want.error));
                    check_field("scrolled", 16'(got.scrolled), 16'(want.scrolled));
                    check_field("cell_char", 16'(got.cell_char), 16'(want.cell_char));
                    check_field("cell_attribute", 16'(got.cell_attribute),
                                16'(want.cell_attribute));
                    results_checked++;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_DEFAULT_ATTR:  dflt_attr     = pwdata[7:0];
                    REG_ERROR_ATTR:    err_attr      = pwdata[7:0];
                    REG_CURSOR_FOLLOW: follow_cursor = pwdata[0];
                    default:           ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predicted = apply_word(op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[16],
                                       s_tdata[23:17], s_tdata[28:24]);
                expected_q.push_back(predicted);
                if (predicted.scrolled)
                    scroll_total++;
                if (predicted.error)
                    range_total++;
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: verif/tb_text_console_writer.sv
// Testbench top for the text console writer: clock, reset, stimulus, flow control and verdict.
module tb_text_console_writer
    import tcw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = DEF_COLUMNS * DEF_ROWS;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // char_code, attribute, use_position, column, line
    logic [1:0]  s_tuser  = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // next_position, cursor_now, error, scrolled,
                                  // cell_char, cell_attribute
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results_checked;
    int scroll_total;
    int range_total;
    int words_sent    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int style         = 0;
    int style_left    = 0;

    text_console_writer uut (.*);
    tcw_checker chk (.*);

    always #1 clk = ~clk;

    // receiver flow control: long hold on request, else a self-chosen stall style
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_served < hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= 400;
            m_tready     <= 1'b0;
        end else begin
            if (style_left == 0) begin
                style      <= $urandom_range(0, 2);
                style_left <= $urandom_range(20, 300);
            end else
                style_left <= style_left - 1;
            case (style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_word(op_t op, logic [7:0] ch, logic [7:0] attr, logic use_pos,
                             logic [6:0] col, logic [4:0] row);
        s_tuser  <= op;
        s_tdata  <= {3'b000, row, col, use_pos, attr, ch};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // only while idle; the pause lets a scroll or clear walk finish first
    task automatic reconfigure(logic [7:0] dflt, logic [7:0] err, logic follow);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (CELLS + 16) @(posedge clk);
        reg_write(REG_DEFAULT_ATTR, {24'd0, dflt});
        reg_write(REG_ERROR_ATTR, {24'd0, err});
        reg_write(REG_CURSOR_FOLLOW, {31'd0, follow});
    endtask

    task automatic random_phase(int count, bit dense);
        int         burst_left;
        int         roll;
        bit         text_run;
        op_t        op;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       use_pos;
        logic [6:0] col;
        logic [4:0] row;
        burst_left = 0;
        text_run   = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (burst_left == 0) begin
                if (!dense)
                    pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 48);
                text_run   = ($urandom_range(0, 1) == 0);
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            if (text_run)
                op = (roll < 5) ? OP_BACKSPACE : (roll < 10) ? OP_READ : OP_PRINT;
            else
                op = (roll < 2) ? OP_CLEAR : (roll < 10) ? OP_BACKSPACE :
                     (roll < 24) ? OP_READ : OP_PRINT;
            ch      = ($urandom_range(0, 9) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255));
            attr    = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            use_pos = text_run ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 1) == 1);
            roll    = $urandom_range(0, 9);
            col     = (roll == 0) ? 7'($urandom_range(0, 127)) :
                      (roll == 1) ? 7'(DEF_COLUMNS - 1) : 7'($urandom_range(0, DEF_COLUMNS - 1));
            roll    = $urandom_range(0, 9);
            row     = (roll == 0) ? 5'($urandom_range(0, 31)) :
                      (roll < 3) ? 5'(DEF_ROWS - 1) : 5'($urandom_range(0, DEF_ROWS - 1));
            send_word(op, ch, attr, use_pos, col, row);
        end
    endtask

    initial begin
        #40_000_000;
        $display("tb_text_console_writer NOT OK");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, cursor follows
        send_word(OP_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_BACKSPACE, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_PRINT, 8'h41, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_PRINT, 8'hFF, 8'hFF, 1'b0, 7'd0, 5'd0);
        send_word(OP_PRINT, 8'h00, 8'h01, 1'b1, 7'(DEF_COLUMNS - 1), 5'd0);
        send_word(OP_PRINT, CH_NEWLINE, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_BACKSPACE, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0);
        send_word(OP_PRINT, 8'h55, 8'h12, 1'b1, 7'd127, 5'd31);
        send_word(OP_PRINT, 8'h55, 8'h12, 1'b1, 7'(DEF_COLUMNS), 5'd0);
        send_word(OP_PRINT, 8'h55, 8'h12, 1'b1, 7'd0, 5'(DEF_ROWS));
        send_word(OP_READ, 8'h00, 8'h00, 1'b1, 7'(DEF_COLUMNS - 1), 5'(DEF_ROWS - 1));
        send_word(OP_READ, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd0);
        send_word(OP_PRINT, 8'h7A, 8'h80, 1'b1, 7'(DEF_COLUMNS - 1), 5'(DEF_ROWS - 1));
        send_word(OP_PRINT, CH_NEWLINE, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_PRINT, CH_NEWLINE, 8'h33, 1'b1, 7'd5, 5'(DEF_ROWS - 1));
        send_word(OP_READ, 8'h00, 8'h00, 1'b1, 7'(DEF_COLUMNS - 1), 5'(DEF_ROWS - 2));
        send_word(OP_CLEAR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_READ, 8'h00, 8'h00, 1'b1, 7'd10, 5'd10);
        send_word(OP_PRINT, CH_NEWLINE, 8'h00, 1'b1, 7'(DEF_COLUMNS - 1), 5'd3);
        random_phase(250, 1'b0);

        // cursor frozen, zero default attribute
        reconfigure(8'h00, 8'hFF, 1'b0);
        send_word(OP_PRINT, 8'h51, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_PRINT, CH_NEWLINE, 8'h00, 1'b1, 7'd0, 5'(DEF_ROWS - 1));
        send_word(OP_BACKSPACE, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        send_word(OP_PRINT, 8'h20, 8'h00, 1'b1, 7'd100, 5'd30);
        send_word(OP_READ, 8'h00, 8'h00, 1'b1, 7'(DEF_COLUMNS - 1), 5'(DEF_ROWS - 1));
        random_phase(250, 1'b0);

        // long receiver hold while the sender keeps pushing, then a full drain
        reconfigure(8'hFF, 8'h00, 1'b1);
        random_phase(150, 1'b0);
        hold_requests <= hold_requests + 1;
        random_phase(40, 1'b1);
        s_tvalid <= 1'b0;
        wait_drained();
        random_phase(200, 1'b0);

        reconfigure(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)), 1'b0);
        random_phase(250, 1'b0);
        reconfigure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
        random_phase(250, 1'b0);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d command words and %0d checked results over five settings,",
                 words_sent, results_checked);
        $display("including %0d scrolls and %0d out-of-range positions.",
                 scroll_total, range_total);
        if (mismatches == 0)
            $display("tb_text_console_writer OK");
        else
            $display("tb_text_console_writer NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
verif/tcw_checker.sv
verif/tb_text_console_writer.sv
